// ===== design/kst_pkg.sv =====
`timescale 1ns / 1ps

package kst_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W = 64;
  localparam int KEY_BYTES = KEY_W / 8;
  localparam int LEN_W = 4;
  localparam int SLOT_W = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W = KEY_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ID_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BYTES = 2'd1;

  localparam logic [LEN_W-1:0] ID_BYTES_RESET = 4'd4;
  localparam logic [LEN_W-1:0] INDEX_BYTES_RESET = 4'd4;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] id_len,
                                                input logic [LEN_W-1:0] index_len);
    logic [LEN_W:0] n;
    logic [KEY_W-1:0] m;
    n = {1'b0, id_len} + {1'b0, index_len};
    m = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (n > (LEN_W + 1)'(b)) begin
        m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// ===== design/kst_ram.sv =====
`timescale 1ns / 1ps

module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/key_slot_table.sv =====
`timescale 1ns / 1ps

// Key slot table: insert places a key in the lowest empty slot below the
// high-water mark, or at the mark (raising it), or reports full; remove clears
// the lowest valid slot whose key matches under the current id/index length,
// or reports not found. One request is handled at a time; a request scans the
// slot memory through its single read port, one slot per cycle, reading at most
// high_water slots (at most TABLE_ENTRIES) before its result is registered, and
// the result may then wait for the result register to drain. A slot at or above the
// high-water mark counts as empty, so no clearing pass runs after reset.
module key_slot_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [kst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kst_pkg::LEN_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [kst_pkg::KEY_W-1:0]     key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kst_pkg::STATUS_W-1:0]  status,
  output logic [kst_pkg::SLOT_W-1:0]    slot
);

  kst_pkg::state_t state, state_next;

  logic [kst_pkg::LEN_W-1:0] id_bytes, index_bytes;
  logic [kst_pkg::CNT_W-1:0] high_water, high_water_next;
  logic [kst_pkg::CNT_W-1:0] limit, limit_next;
  logic [kst_pkg::CNT_W-1:0] rd_idx, rd_idx_next;
  logic                      pend, pend_next;
  logic [kst_pkg::IDX_W-1:0] pend_idx, pend_idx_next;
  logic                      kind_r, kind_r_next;
  logic [kst_pkg::KEY_W-1:0] key_r, key_r_next;
  logic [kst_pkg::KEY_W-1:0] mask;

  logic [kst_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [kst_pkg::SLOT_W-1:0]   res_slot, res_slot_next;
  logic                         out_valid_next;
  logic [kst_pkg::STATUS_W-1:0] status_next;
  logic [kst_pkg::SLOT_W-1:0]   slot_next;

  logic                         ram_we, ram_re;
  logic [kst_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [kst_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic                         entry_valid;
  logic [kst_pkg::KEY_W-1:0]    entry_key;
  logic                         hit;

  kst_ram #(
    .WIDTH(kst_pkg::ENTRY_W),
    .DEPTH(kst_pkg::TABLE_ENTRIES)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign mask = kst_pkg::key_mask(id_bytes, index_bytes);
  assign entry_valid = ram_rdata[kst_pkg::KEY_W];
  assign entry_key = ram_rdata[kst_pkg::KEY_W-1:0];

  always_comb begin
    if (kind_r == kst_pkg::KIND_INSERT) begin
      hit = pend && !entry_valid;
    end else begin
      hit = pend && entry_valid && ((entry_key & mask) == key_r);
    end
  end

  always_comb begin
    state_next = state;
    high_water_next = high_water;
    limit_next = limit;
    rd_idx_next = rd_idx;
    pend_next = pend;
    pend_idx_next = pend_idx;
    kind_r_next = kind_r;
    key_r_next = key_r;
    res_status_next = res_status;
    res_slot_next = res_slot;
    out_valid_next = out_valid && !out_ready;
    status_next = status;
    slot_next = slot;
    in_ready = 1'b0;
    ram_we = 1'b0;
    ram_waddr = pend_idx;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = rd_idx[kst_pkg::IDX_W-1:0];

    case (state)
      kst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_r_next = kind;
          key_r_next = key & mask;
          limit_next = high_water;
          rd_idx_next = '0;
          pend_next = 1'b0;
          state_next = kst_pkg::ST_SCAN;
        end
      end
      kst_pkg::ST_SCAN: begin
        if (hit) begin
          ram_we = 1'b1;
          ram_waddr = pend_idx;
          ram_wdata = (kind_r == kst_pkg::KIND_INSERT) ? {1'b1, key_r} : '0;
          res_status_next = kst_pkg::STATUS_DONE;
          res_slot_next = kst_pkg::SLOT_W'(pend_idx);
          pend_next = 1'b0;
          state_next = kst_pkg::ST_RESULT;
        end else if (rd_idx < limit) begin
          ram_re = 1'b1;
          pend_next = 1'b1;
          pend_idx_next = rd_idx[kst_pkg::IDX_W-1:0];
          rd_idx_next = rd_idx + 1'b1;
        end else begin
          pend_next = 1'b0;
          state_next = kst_pkg::ST_RESULT;
          res_slot_next = '0;
          if (kind_r == kst_pkg::KIND_REMOVE) begin
            res_status_next = kst_pkg::STATUS_NOT_FOUND;
          end else if (limit < kst_pkg::CNT_W'(kst_pkg::TABLE_ENTRIES)) begin
            ram_we = 1'b1;
            ram_waddr = limit[kst_pkg::IDX_W-1:0];
            ram_wdata = {1'b1, key_r};
            high_water_next = limit + 1'b1;
            res_status_next = kst_pkg::STATUS_DONE;
            res_slot_next = kst_pkg::SLOT_W'(limit);
          end else begin
            res_status_next = kst_pkg::STATUS_FULL;
          end
        end
      end
      kst_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          status_next = res_status;
          slot_next = res_slot;
          state_next = kst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kst_pkg::ST_IDLE;
      high_water <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      high_water <= high_water_next;
      pend <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    limit <= limit_next;
    rd_idx <= rd_idx_next;
    pend_idx <= pend_idx_next;
    kind_r <= kind_r_next;
    key_r <= key_r_next;
    res_status <= res_status_next;
    res_slot <= res_slot_next;
    status <= status_next;
    slot <= slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_bytes <= kst_pkg::ID_BYTES_RESET;
      index_bytes <= kst_pkg::INDEX_BYTES_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        kst_pkg::REG_ID_BYTES:    id_bytes <= cfg_data;
        kst_pkg::REG_INDEX_BYTES: index_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== tb/key_slot_table_test.sv =====
`timescale 1ns / 1ps

module key_slot_table_test;
  import kst_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 68;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } result_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_LENGTHS
  } row_kind_t;

  typedef struct {
    row_kind_t        what;
    logic             op;
    logic [KEY_W-1:0] value;
    logic [LEN_W-1:0] id_len;
    logic [LEN_W-1:0] index_len;
    bit               typed;
    result_t          want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 kind = KIND_INSERT;
  logic [KEY_W-1:0]     key = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot;

  logic [KEY_W-1:0] shadow_key [TABLE_ENTRIES];
  logic             shadow_valid [TABLE_ENTRIES];
  int               shadow_mark = 0;
  logic [LEN_W-1:0] cur_id_len = ID_BYTES_RESET;
  logic [LEN_W-1:0] cur_index_len = INDEX_BYTES_RESET;

  result_t  pending_results [$];
  dir_row_t directed [$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       take_stall_pct = 0;
  logic     hold_results = 1'b0;

  int phase_id [PHASES]     = '{4, 0, 8, 15, 1, 3, 0, 2};
  int phase_index [PHASES]  = '{4, 0, 8, 15, 2, 5, 8, 0};
  int insert_pct [PHASES]   = '{80, 60, 85, 40, 75, 30, 80, 50};

  key_slot_table u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .slot      (slot)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [KEY_W-1:0] significant_mask();
    int n;
    n = int'(cur_id_len) + int'(cur_index_len);
    if (n >= KEY_BYTES) return '1;
    return (KEY_W'(1) << (8 * n)) - KEY_W'(1);
  endfunction

  function automatic result_t apply_request(input logic op, input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] k;
    int      hit;
    result_t res;
    m = significant_mask();
    k = raw & m;
    hit = -1;
    res.status = STATUS_DONE;
    res.slot = '0;
    if (op == KIND_INSERT) begin
      for (int i = 0; i < shadow_mark; i++) begin
        if (!shadow_valid[i] && hit < 0) hit = i;
      end
      if (hit < 0 && shadow_mark < TABLE_ENTRIES) begin
        hit = shadow_mark;
        shadow_mark++;
      end
      if (hit < 0) begin
        res.status = STATUS_FULL;
      end else begin
        shadow_key[hit] = k;
        shadow_valid[hit] = 1'b1;
        res.slot = SLOT_W'(hit);
      end
    end else begin
      for (int i = 0; i < shadow_mark; i++) begin
        if (hit < 0 && shadow_valid[i] && (shadow_key[i] & m) == k) hit = i;
      end
      if (hit < 0) begin
        res.status = STATUS_NOT_FOUND;
      end else begin
        shadow_valid[hit] = 1'b0;
        shadow_key[hit] = '0;
        res.slot = SLOT_W'(hit);
      end
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return KEY_W'($urandom_range(3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly look up a stored key, with noise in the bytes that do not count
  function automatic logic [KEY_W-1:0] lookup_key();
    int held [$];
    for (int i = 0; i < shadow_mark; i++) begin
      if (shadow_valid[i]) held.push_back(i);
    end
    if (held.size() == 0 || $urandom_range(99) < 35) return random_key();
    return shadow_key[held[$urandom_range(held.size() - 1)]] |
           ({$urandom, $urandom} & ~significant_mask());
  endfunction

  function automatic dir_row_t checked_row(input logic op, input logic [KEY_W-1:0] value,
                                           input logic [STATUS_W-1:0] st,
                                           input int sl);
    dir_row_t r;
    r.what = ROW_REQUEST;
    r.op = op;
    r.value = value;
    r.id_len = '0;
    r.index_len = '0;
    r.typed = 1'b1;
    r.want.status = st;
    r.want.slot = SLOT_W'(sl);
    return r;
  endfunction

  function automatic dir_row_t predicted_row(input logic op, input logic [KEY_W-1:0] value);
    dir_row_t r;
    r = checked_row(op, value, STATUS_DONE, 0);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t length_row(input int id_len, input int index_len);
    dir_row_t r;
    r = checked_row(KIND_INSERT, '0, STATUS_DONE, 0);
    r.what = ROW_LENGTHS;
    r.id_len = LEN_W'(id_len);
    r.index_len = LEN_W'(index_len);
    r.typed = 1'b0;
    return r;
  endfunction

  // hold each request until accepted, then record what it must produce
  task automatic send_request(input logic op, input logic [KEY_W-1:0] value,
                              input bit typed, input result_t want);
    result_t res;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    key <= value;
    do @(posedge clk); while (!in_ready);
    res = apply_request(op, value);
    pending_results.push_back(typed ? want : res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic program_regs(input logic [LEN_W-1:0] id_len,
                              input logic [LEN_W-1:0] index_len);
    cfg_wen <= 1'b1;
    cfg_index <= REG_ID_BYTES;
    cfg_data <= id_len;
    @(posedge clk);
    cfg_index <= REG_INDEX_BYTES;
    cfg_data <= index_len;
    @(posedge clk);
    cfg_index <= ($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
    cfg_data <= LEN_W'($urandom);
    @(posedge clk);
    cfg_wen <= 1'b0;
    cur_id_len = id_len;
    cur_index_len = index_len;
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        hold_results <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (take_stall_pct != 0 && $urandom_range(99) < take_stall_pct) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : take_result
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result count (none outstanding), slot", -1, slot);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", want.status, status);
        if (slot !== want.slot) report_mismatch("slot", want.slot, slot);
      end
    end
  end

  initial begin : stimulus
    dir_row_t r;
    logic     op;
    result_t  none;
    none = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_key[i] = '0;
      shadow_valid[i] = 1'b0;
    end

    directed.push_back(checked_row(KIND_REMOVE, '0, STATUS_NOT_FOUND, 0));
    directed.push_back(checked_row(KIND_INSERT, '0, STATUS_DONE, 0));
    directed.push_back(checked_row(KIND_INSERT, '1, STATUS_DONE, 1));
    directed.push_back(checked_row(KIND_INSERT, '1, STATUS_DONE, 2));
    directed.push_back(checked_row(KIND_INSERT, 64'h0123_4567_89ab_cdef, STATUS_DONE, 3));
    directed.push_back(checked_row(KIND_REMOVE, '1, STATUS_DONE, 1));
    directed.push_back(checked_row(KIND_REMOVE, 64'h5555_5555_5555_5555,
                                   STATUS_NOT_FOUND, 0));
    directed.push_back(checked_row(KIND_INSERT, 64'haaaa_aaaa_aaaa_aaaa, STATUS_DONE, 1));
    directed.push_back(checked_row(KIND_REMOVE, '0, STATUS_DONE, 0));
    directed.push_back(checked_row(KIND_REMOVE, '0, STATUS_NOT_FOUND, 0));
    directed.push_back(length_row(0, 0));
    directed.push_back(checked_row(KIND_REMOVE, 64'hdead_beef_cafe_f00d, STATUS_DONE, 1));
    directed.push_back(checked_row(KIND_INSERT, 64'h1234, STATUS_DONE, 0));
    directed.push_back(length_row(2, 1));
    directed.push_back(checked_row(KIND_REMOVE, 64'hffff_ffff_ffab_cdef, STATUS_DONE, 3));
    directed.push_back(length_row(15, 15));
    directed.push_back(checked_row(KIND_REMOVE, 64'hffff_ffff_ffff_fffe,
                                   STATUS_NOT_FOUND, 0));
    directed.push_back(checked_row(KIND_REMOVE, '1, STATUS_DONE, 2));
    directed.push_back(checked_row(KIND_INSERT, 64'h8000_0000_0000_0001, STATUS_DONE, 1));
    directed.push_back(length_row(0, 8));
    directed.push_back(checked_row(KIND_INSERT, {$urandom, $urandom}, STATUS_DONE, 2));
    directed.push_back(checked_row(KIND_INSERT, {$urandom, $urandom}, STATUS_DONE, 3));
    directed.push_back(checked_row(KIND_INSERT, {$urandom, $urandom}, STATUS_DONE, 4));
    directed.push_back(predicted_row(KIND_REMOVE, 64'h8000_0000_0000_0001));
    directed.push_back(predicted_row(KIND_REMOVE, '0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      r = directed[i];
      if (r.what == ROW_LENGTHS) begin
        drain_results();
        program_regs(r.id_len, r.index_len);
      end else begin
        send_request(r.op, r.value, r.typed, r.want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      program_regs(LEN_W'(phase_id[p]), LEN_W'(phase_index[p]));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          take_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 58;
          take_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          take_stall_pct = 58;
        end
        default: begin
          send_idle_pct = 24;
          take_stall_pct = 24;
        end
      endcase
      // back up the block: results held while requests keep coming
      if (p == 1) hold_results <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) drain_results();
        op = ($urandom_range(99) < insert_pct[p]) ? KIND_INSERT : KIND_REMOVE;
        send_request(op, (op == KIND_REMOVE) ? lookup_key() : random_key(), 1'b0, none);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
